/* hw/rtl/lrucc_pkg.sv */
`timescale 1ns / 1ps

package lrucc_pkg;

  localparam int unsigned MaxEntriesDefault = 32;
  localparam int unsigned KeyWidth          = 64;
  localparam int unsigned CfgWidth          = 6;
  localparam int unsigned CostWidth         = 3;
  localparam int unsigned TotalWidth        = 32;

  localparam logic [CostWidth-1:0] HIT_COST  = 3'd1;
  localparam logic [CostWidth-1:0] MISS_COST = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOOK = 4'b0010,
    ST_UPD  = 4'b0100,
    ST_HOLD = 4'b1000
  } state_e;

  typedef enum logic [1:0] {
    TGT_HIT     = 2'd0,
    TGT_INSERT  = 2'd1,
    TGT_REPLACE = 2'd2
  } tgt_e;

  typedef struct packed {
    logic cmp_en;
    logic upd_en;
    tgt_e tgt;
  } cmd_t;

  function automatic logic [KeyWidth-1:0] fold_key(input logic [KeyWidth-1:0] k);
    logic [KeyWidth-1:0] r;
    logic [7:0]          c;
    r = '0;
    for (int b = 0; b < KeyWidth / 8; b++) begin
      c = k[8*b +: 8];
      if (c >= 8'h41 && c <= 8'h5a) begin
        c = c + 8'h20;
      end
      r[8*b +: 8] = c;
    end
    return r;
  endfunction

endpackage

/* hw/rtl/lrucc_cell.sv */
`timescale 1ns / 1ps

module lrucc_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned OW  = 6,
  parameter int unsigned RW  = 5
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [lrucc_pkg::KeyWidth-1:0] key_i,
  input  lrucc_pkg::cmd_t              cmd_i,
  input  logic [OW-1:0]                occ_i,
  input  logic [RW-1:0]                limit_i,
  input  logic                         hit_i,
  input  logic [RW-1:0]                rank_i,
  output logic                         hit_o,
  output logic [RW-1:0]                rank_o
);
  import lrucc_pkg::*;

  logic                valid_q, valid_d;
  logic [RW-1:0]       rank_q, rank_d;
  logic                match_q, match_d;
  logic [KeyWidth-1:0] key_q;
  logic                target;
  logic                write_key;

  assign hit_o  = hit_i | match_q;
  assign rank_o = rank_i | (match_q ? rank_q : '0);

  always_comb begin
    unique case (cmd_i.tgt)
      TGT_HIT:     target = match_q;
      TGT_INSERT:  target = (occ_i == OW'(IDX));
      TGT_REPLACE: target = valid_q && (rank_q == limit_i);
      default:     target = 1'b0;
    endcase
  end

  assign write_key = cmd_i.upd_en && target && (cmd_i.tgt != TGT_HIT);

  always_comb begin
    valid_d = valid_q;
    rank_d  = rank_q;
    match_d = match_q;
    if (cmd_i.cmp_en) begin
      match_d = valid_q && (key_q == key_i);
    end
    if (cmd_i.upd_en) begin
      if (target) begin
        valid_d = 1'b1;
        rank_d  = '0;
      end else if (valid_q && ((cmd_i.tgt == TGT_INSERT) || (rank_q < limit_i))) begin
        rank_d = rank_q + RW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rank_q  <= '0;
      match_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      rank_q  <= rank_d;
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (write_key) begin
      key_q <= key_i;
    end
  end

endmodule

/* hw/rtl/lru_cache_hit_cost_counter_top.sv */
`timescale 1ns / 1ps

// Fully associative LRU cache with access cost accounting.
// The input channel (in_valid_i/in_ready_o) carries one access key per
// transaction; letters A to Z are folded to lower case before the lookup.
// The output channel (out_valid_o/out_ready_i) returns one result per access:
// the hit flag, the cost of the access and the saturating running total.
// The configuration channel (cfg_valid_i/cfg_ready_o) writes the cache size
// and is always ready; it should be written only while the block is idle.
// Each stored entry lives in one cell of a row; the cells compare the key in
// the cycle after acceptance and update their recency ranks in the next; the
// result then goes to the output register. A new key is taken only in the
// idle step, after the last access has passed its compare and update steps.
// A result that the receiver stalls waits in the output register while the
// next access is accepted; the next result then waits until that one is taken.
// Reset empties the cache, clears the total and sets the size to zero.
module lru_cache_hit_cost_counter_top #(
  parameter int unsigned MAX_ENTRIES = lrucc_pkg::MaxEntriesDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [lrucc_pkg::CfgWidth-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [lrucc_pkg::KeyWidth-1:0]  key_text_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            hit_o,
  output logic [lrucc_pkg::CostWidth-1:0] access_cost_o,
  output logic [lrucc_pkg::TotalWidth-1:0] total_cost_o
);
  import lrucc_pkg::*;

  localparam int unsigned OW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned RW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW = (OW > CfgWidth) ? OW : CfgWidth;

  state_e                state_q, state_d;
  logic [CfgWidth-1:0]   size_cfg_q;
  logic [KeyWidth-1:0]   key_q;
  logic [OW-1:0]         occ_q, occ_d;
  logic [TotalWidth-1:0] total_q, total_d;
  logic                  pend_hit_q, pend_hit_d;
  logic                  out_valid_q, out_valid_d;
  logic                  out_hit_q;
  logic [TotalWidth-1:0] out_total_q;
  logic                  load_out;

  cmd_t                  cmd;
  logic [RW-1:0]         limit;
  logic [CW-1:0]         size_w;
  logic [CW-1:0]         occ_w;
  logic [TotalWidth:0]   sum;
  logic [CostWidth-1:0]  cost;
  logic                  hit_c  [0:MAX_ENTRIES];
  logic [RW-1:0]         rank_c [0:MAX_ENTRIES];

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);

  assign size_w = (CW'(size_cfg_q) > CW'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : CW'(size_cfg_q);
  assign occ_w  = CW'(occ_q);

  assign hit_c[0]  = 1'b0;
  assign rank_c[0] = '0;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    lrucc_cell #(
      .IDX (i),
      .OW  (OW),
      .RW  (RW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .key_i   (key_q),
      .cmd_i   (cmd),
      .occ_i   (occ_q),
      .limit_i (limit),
      .hit_i   (hit_c[i]),
      .rank_i  (rank_c[i]),
      .hit_o   (hit_c[i+1]),
      .rank_o  (rank_c[i+1])
    );
  end

  always_comb begin
    cmd.cmp_en = (state_q == ST_LOOK);
    cmd.upd_en = 1'b0;
    cmd.tgt    = TGT_HIT;
    limit      = rank_c[MAX_ENTRIES];
    occ_d      = occ_q;
    pend_hit_d = pend_hit_q;
    if (state_q == ST_UPD) begin
      pend_hit_d = 1'b0;
      if (size_w != '0) begin
        cmd.upd_en = 1'b1;
        if (hit_c[MAX_ENTRIES]) begin
          pend_hit_d = 1'b1;
        end else if (occ_w < size_w) begin
          cmd.tgt = TGT_INSERT;
          occ_d   = occ_q + OW'(1);
        end else begin
          cmd.tgt = TGT_REPLACE;
          limit   = RW'(occ_q - OW'(1));
        end
      end
    end
  end

  assign cost    = pend_hit_d ? HIT_COST : MISS_COST;
  assign sum     = {1'b0, total_q} + (TotalWidth + 1)'(cost);
  assign total_d = sum[TotalWidth] ? '1 : sum[TotalWidth-1:0];

  always_comb begin
    state_d     = state_q;
    load_out    = 1'b0;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: state_d = ST_UPD;
      ST_UPD: begin
        if (!out_valid_q || out_ready_i) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end else begin
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_ready_i) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      size_cfg_q  <= '0;
      occ_q       <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        size_cfg_q <= cfg_data_i;
      end
      if (state_q == ST_UPD) begin
        total_q <= total_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      key_q <= fold_key(key_text_i);
    end
    if (state_q == ST_UPD) begin
      pend_hit_q <= pend_hit_d;
    end
    if (load_out) begin
      out_hit_q   <= (state_q == ST_UPD) ? pend_hit_d : pend_hit_q;
      out_total_q <= (state_q == ST_UPD) ? total_d : total_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign hit_o         = out_hit_q;
  assign access_cost_o = out_hit_q ? HIT_COST : MISS_COST;
  assign total_cost_o  = out_total_q;

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import lrucc_pkg::*;

  localparam int unsigned SLOTS       = MaxEntriesDefault;
  localparam int unsigned POOL        = 48;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic                  hit;
    logic [CostWidth-1:0]  cost;
    logic [TotalWidth-1:0] total;
  } access_result_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CfgWidth-1:0]   cfg_data_i    = '0;
  logic                  in_valid_i    = 1'b0;
  logic                  in_ready_o;
  logic [KeyWidth-1:0]   key_text_i    = '0;
  logic                  out_valid_o;
  logic                  out_ready_i   = 1'b1;
  logic                  hit_o;
  logic [CostWidth-1:0]  access_cost_o;
  logic [TotalWidth-1:0] total_cost_o;

  // Shadow copy of the cache contents, recency order and running cost.
  logic [KeyWidth-1:0]   cache_key  [SLOTS];
  int unsigned           cache_rank [SLOTS];
  int unsigned           fill_level = 0;
  logic [TotalWidth-1:0] cost_sum   = '0;
  logic [CfgWidth-1:0]   size_reg   = '0;

  access_result_t        pending_results [$];
  logic [KeyWidth-1:0]   key_pool [POOL];
  int                    mismatch_count = 0;
  int                    cycle_count    = 0;
  bit                    idle_on        = 1'b1;

  lru_cache_hit_cost_counter_top #(
    .MAX_ENTRIES(SLOTS)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .key_text_i   (key_text_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .hit_o        (hit_o),
    .access_cost_o(access_cost_o),
    .total_cost_o (total_cost_o)
  );

  always #2 clk_i = ~clk_i;

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      cache_key[i]  = '0;
      cache_rank[i] = 0;
    end
  end

  function automatic logic [KeyWidth-1:0] fold_letters(logic [KeyWidth-1:0] k);
    logic [KeyWidth-1:0] r;
    logic [7:0]          c;
    r = k;
    for (int b = 0; b < KeyWidth / 8; b++) begin
      c = k[8*b +: 8];
      if (c >= 8'h41 && c <= 8'h5a) begin
        r[8*b +: 8] = c + 8'h20;
      end
    end
    return r;
  endfunction

  function automatic void touch_entry(int unsigned slot, int unsigned limit);
    for (int unsigned i = 0; i < fill_level; i++) begin
      if (i != slot && cache_rank[i] < limit) begin
        cache_rank[i] = cache_rank[i] + 1;
      end
    end
    cache_rank[slot] = 0;
  endfunction

  function automatic access_result_t predict_access(logic [KeyWidth-1:0] raw);
    access_result_t      res;
    logic [KeyWidth-1:0] key;
    int unsigned         lim;
    int unsigned         slot;
    int unsigned         victim;
    logic                found;
    logic [CostWidth-1:0] cost;
    key   = fold_letters(raw);
    lim   = (size_reg > SLOTS) ? SLOTS : size_reg;
    found = 1'b0;
    slot  = 0;
    if (lim != 0) begin
      for (int unsigned i = 0; i < fill_level; i++) begin
        if (!found && cache_key[i] == key) begin
          found = 1'b1;
          slot  = i;
        end
      end
      if (found) begin
        touch_entry(slot, cache_rank[slot]);
      end else if (fill_level < lim) begin
        cache_key[fill_level] = key;
        fill_level++;
        touch_entry(fill_level - 1, 32'hFFFF);
      end else begin
        victim = 0;
        for (int unsigned i = 1; i < fill_level; i++) begin
          if (cache_rank[i] > cache_rank[victim]) begin
            victim = i;
          end
        end
        cache_key[victim] = key;
        touch_entry(victim, cache_rank[victim]);
      end
    end
    cost = found ? HIT_COST : MISS_COST;
    if (cost_sum > 32'hFFFF_FFFF - cost) begin
      cost_sum = 32'hFFFF_FFFF;
    end else begin
      cost_sum = cost_sum + cost;
    end
    res.hit   = found;
    res.cost  = cost;
    res.total = cost_sum;
    return res;
  endfunction

  function automatic logic [7:0] odd_byte();
    case ($urandom_range(0, 6))
      0:       return 8'h40;
      1:       return 8'h5b;
      2:       return 8'h60;
      3:       return 8'h7b;
      4:       return 8'h00;
      5:       return 8'hc1;
      default: return 8'h30 + 8'($urandom_range(0, 9));
    endcase
  endfunction

  function automatic logic [KeyWidth-1:0] make_word();
    logic [KeyWidth-1:0] w;
    int                  len;
    w   = '0;
    len = $urandom_range(1, 8);
    for (int b = 0; b < len; b++) begin
      if ($urandom_range(0, 9) == 0) begin
        w[8*b +: 8] = odd_byte();
      end else begin
        w[8*b +: 8] = 8'h61 + 8'($urandom_range(0, 25));
      end
    end
    return w;
  endfunction

  function automatic logic [KeyWidth-1:0] vary_case(logic [KeyWidth-1:0] k);
    logic [KeyWidth-1:0] r;
    logic [7:0]          c;
    r = k;
    for (int b = 0; b < KeyWidth / 8; b++) begin
      c = k[8*b +: 8];
      if (c >= 8'h61 && c <= 8'h7a && $urandom_range(0, 1) == 1) begin
        r[8*b +: 8] = c - 8'h20;
      end
    end
    return r;
  endfunction

  function automatic logic [KeyWidth-1:0] pick_key(int unsigned span);
    if ($urandom_range(0, 9) == 0) begin
      if ($urandom_range(0, 1) == 1) begin
        return {$urandom, $urandom};
      end
      return vary_case(make_word());
    end
    return vary_case(key_pool[$urandom_range(0, span - 1)]);
  endfunction

  function automatic logic [CfgWidth-1:0] phase_size(int p);
    case (p)
      0:       return 6'd2;
      1:       return 6'd32;
      2:       return 6'd63;
      3:       return 6'd7;
      4:       return 6'd1;
      5:       return 6'd0;
      6:       return 6'd40;
      7:       return 6'd16;
      8:       return 6'd3;
      default: return 6'd31;
    endcase
  endfunction

  task automatic send_access(logic [KeyWidth-1:0] key);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
    end
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    key_text_i <= key;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.insert(pending_results.size(), predict_access(key));
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_size(logic [CfgWidth-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    size_reg = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_size_zero();
    send_access(64'h0000_006f_6c6c_6548);
    send_access(64'h0000_006f_6c6c_6548);
    send_access(64'h0);
  endtask

  task automatic test_case_folding();
    settle();
    write_size(6'd3);
    send_access(64'h0000_006f_6c6c_6548);
    send_access(64'h0000_004f_4c4c_4568);
    send_access(64'h0000_004f_4c4c_4548);
    send_access(64'h0);
    send_access(64'hFFFF_FFFF_FFFF_FFFF);
    send_access(64'h0000_0000_7b60_5b40);
    send_access(64'h0000_006f_6c6c_6548);
    send_access(64'h0000_0000_0062_0061);
    send_access(64'h0000_0000_0000_6261);
    send_access(64'h0000_0000_0042_0041);
    send_access(64'hc1da_0000_5a41_0000);
    send_access(64'hc1da_0000_7a61_0000);
  endtask

  task automatic test_lowered_size();
    settle();
    write_size(6'd1);
    send_access(64'h0000_0000_0000_6261);
    send_access(64'h0000_0000_0042_0041);
    send_access(64'h0000_0000_007a_7978);
    send_access(64'h0000_0000_0062_0061);
    settle();
    write_size(6'd0);
    send_access(64'h0000_0000_007a_7978);
    settle();
    write_size(6'd63);
    send_access(64'h0000_0000_005a_5958);
  endtask

  task automatic test_random_traffic();
    int unsigned lim;
    int unsigned span;
    for (int p = 0; p < 10; p++) begin
      settle();
      write_size(phase_size(p));
      lim  = (phase_size(p) > SLOTS) ? SLOTS : phase_size(p);
      span = lim + lim / 2 + 2;
      if (span > POOL) begin
        span = POOL;
      end
      for (int n = 0; n < 70; n++) begin
        if (p == 4 && n == 35) begin
          settle();
        end
        send_access(pick_key(span));
      end
    end
  endtask

  task automatic test_quiet_tail();
    settle();
    idle_on = 1'b0;
    write_size(6'd8);
    for (int n = 0; n < 100; n++) begin
      send_access(pick_key(14));
    end
  endtask

  initial begin
    for (int i = 0; i < POOL; i++) begin
      key_pool[i] = make_word();
    end
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_size_zero();
    test_case_folding();
    test_lowered_size();
    test_random_traffic();
    test_quiet_tail();
    settle();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("** lru_cache_hit_cost_counter_top: PASSED **");
    end else begin
      $display("** lru_cache_hit_cost_counter_top: FAILED **");
    end
    $finish;
  end

  initial begin
    forever begin
      @(negedge clk_i);
      if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : check_result
    access_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual hit %b cost %0d total %0d",
                 $time, hit_o, access_cost_o, total_cost_o);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (hit_o !== want.hit) begin
          $display("%0t: hit expected %b actual %b", $time, want.hit, hit_o);
          mismatch_count++;
        end
        if (access_cost_o !== want.cost) begin
          $display("%0t: access_cost expected %0d actual %0d", $time, want.cost,
                   access_cost_o);
          mismatch_count++;
        end
        if (total_cost_o !== want.total) begin
          $display("%0t: total_cost expected %0d actual %0d", $time, want.total,
                   total_cost_o);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** lru_cache_hit_cost_counter_top: FAILED **");
      $finish;
    end
  end

endmodule
